### src/nfci_pkg.sv
// Package of types, constants and helpers for the NAND flash command interface.
package nfci_pkg;

   localparam int PAGE_DATA_BYTES = 2048;
   localparam int SPARE_BYTES     = 64;
   localparam int PAGES_PER_BLOCK = 64;
   localparam int BLOCK_COUNT     = 8;
   localparam int PAGE_BYTES      = PAGE_DATA_BYTES + SPARE_BYTES;
   localparam int PAGE_COUNT      = PAGES_PER_BLOCK * BLOCK_COUNT;
   localparam int COL_W           = 12;
   localparam int PREG_AW         = $clog2(PAGE_BYTES);
   localparam int PIDX_W          = $clog2(PAGE_COUNT);
   localparam int PPB_W           = $clog2(PAGES_PER_BLOCK);
   localparam int BLK_W           = $clog2(BLOCK_COUNT) > 0 ? $clog2(BLOCK_COUNT) : 1;
   localparam int STORE_AW        = $clog2(PAGE_COUNT * PAGE_BYTES);
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [39:0] ID_RESET = 40'h589551D3EC;

   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_CMD   = 2'd2;
   localparam logic [1:0] FUNC_ADDR  = 2'd3;

   localparam logic [1:0] FAULT_OK      = 2'd0;
   localparam logic [1:0] FAULT_READ    = 2'd1;
   localparam logic [1:0] FAULT_UNKNOWN = 2'd2;

   localparam logic [7:0] CMD_READ0   = 8'h00;
   localparam logic [7:0] CMD_RNDOUT  = 8'h05;
   localparam logic [7:0] CMD_PROG2   = 8'h10;
   localparam logic [7:0] CMD_READ1   = 8'h30;
   localparam logic [7:0] CMD_ERASE1  = 8'h60;
   localparam logic [7:0] CMD_STATUS  = 8'h70;
   localparam logic [7:0] CMD_PROG1   = 8'h80;
   localparam logic [7:0] CMD_ID      = 8'h90;
   localparam logic [7:0] CMD_ERASE2  = 8'hD0;
   localparam logic [7:0] CMD_RNDOUT2 = 8'hE0;
   localparam logic [7:0] CMD_RESET   = 8'hFF;
   localparam logic [7:0] STATUS_RESET = 8'hC0;

   localparam logic [15:0] HIST_READ   = 16'h0030;
   localparam logic [15:0] HIST_RNDOUT = 16'h05E0;
   localparam logic [15:0] HIST_PROG   = 16'h8010;
   localparam logic [15:0] HIST_ERASE  = 16'h60D0;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] bus_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic [1:0] fault;
   } rsp_type;

   // Item as classified by the front part.
   typedef enum logic [2:0] {
      OP_DIRECT,
      OP_PREG_READ,
      OP_PREG_WRITE,
      OP_LOAD,
      OP_PROGRAM,
      OP_ERASE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [7:0]         data;
      logic [1:0]         fault;
      logic [PREG_AW-1:0] addr;
      logic [23:0]        row;
   } job_type;

   typedef enum logic [2:0] {
      BS_IDLE,
      BS_RD_WAIT,
      BS_COPY,
      BS_ERASE,
      BS_RESP,
      BS_CLEAR
   } back_state_type;

   // Erased pattern for page byte a: all ones in the data area, the spare pattern in the spare area.
   function automatic logic [7:0] erased_byte(input logic [PREG_AW-1:0] a);
      logic [PREG_AW-1:0] i;
      begin
         i = a - PREG_AW'(PAGE_DATA_BYTES);
         if (a < PREG_AW'(PAGE_DATA_BYTES)) erased_byte = 8'hFF;
         else if (i < PREG_AW'(64) && i[3:0] < 4'd2) erased_byte = 8'hFF;
         else erased_byte = 8'h00;
      end
   endfunction

endpackage

### src/nfci_front.sv
// Front part: command decoding, address capture and classification of each transfer.
module nfci_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [39:0]       csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  nfci_pkg::req_type req_data,
   output logic              job_valid,
   input  logic              job_ready,
   output nfci_pkg::job_type job
);

   logic [39:0]            id_ff, id_in;
   logic [15:0]            hist_ff, hist_in;
   logic [7:0]             ab_ff [8];
   logic [7:0]             ab_in [8];
   logic [3:0]             acnt_ff, acnt_in;
   logic [11:0]            col_ff, col_in;
   logic [23:0]            row_ff, row_in;
   logic [7:0]             stat_ff, stat_in;
   logic                   fire;
   logic [11:0]            col_new;
   logic [23:0]            row_hi, row_lo;
   logic [5:0]             id_shift;

   assign req_ready = job_ready;
   assign job_valid = req_valid;
   assign fire      = req_valid && job_ready;

   assign col_new  = {ab_ff[1][3:0], ab_ff[0]};
   assign row_hi   = {ab_ff[4], ab_ff[3], ab_ff[2]};
   assign row_lo   = {ab_ff[2], ab_ff[1], ab_ff[0]};
   assign id_shift = {col_ff[2:0], 3'b000};

   // Next state of the command registers and the job that the transfer produces.
   always_comb begin
      logic [7:0] v;
      v       = req_data.bus_byte;
      id_in   = csr_we ? csr_wdata : id_ff;
      hist_in = hist_ff;
      ab_in   = ab_ff;
      acnt_in = acnt_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      stat_in = stat_ff;
      job.op    = nfci_pkg::OP_DIRECT;
      job.data  = 8'h00;
      job.fault = nfci_pkg::FAULT_OK;
      job.addr  = col_ff[nfci_pkg::PREG_AW-1:0];
      job.row   = row_ff;
      unique case (req_data.func)
         nfci_pkg::FUNC_READ: begin
            unique case (hist_ff[7:0])
               nfci_pkg::CMD_STATUS: job.data = stat_ff;
               nfci_pkg::CMD_ID: begin
                  if (col_ff < 12'd5) begin
                     job.data = 8'(id_ff >> id_shift);
                     col_in   = col_ff + 12'd1;
                  end
               end
               nfci_pkg::CMD_READ0, nfci_pkg::CMD_READ1, nfci_pkg::CMD_RNDOUT2: begin
                  if (col_ff < 12'(nfci_pkg::PAGE_BYTES)) begin
                     job.op = nfci_pkg::OP_PREG_READ;
                     col_in = col_ff + 12'd1;
                  end
               end
               default: job.fault = nfci_pkg::FAULT_READ;
            endcase
         end
         nfci_pkg::FUNC_WRITE: begin
            if (col_ff < 12'(nfci_pkg::PAGE_BYTES)) begin
               job.op   = nfci_pkg::OP_PREG_WRITE;
               job.data = v;
               col_in   = col_ff + 12'd1;
            end
         end
         nfci_pkg::FUNC_CMD: begin
            hist_in = {hist_ff[7:0], v};
            unique case (v)
               nfci_pkg::CMD_READ0, nfci_pkg::CMD_RNDOUT, nfci_pkg::CMD_ERASE1,
               nfci_pkg::CMD_ID: begin
                  for (int k = 0; k < 8; k++) ab_in[k] = 8'h00;
                  acnt_in = 4'd0;
               end
               nfci_pkg::CMD_PROG1: begin
                  for (int k = 0; k < 8; k++) ab_in[k] = 8'h00;
                  acnt_in = 4'd0;
                  col_in  = 12'd0;
               end
               nfci_pkg::CMD_RESET: begin
                  for (int k = 0; k < 8; k++) ab_in[k] = 8'h00;
                  acnt_in = 4'd0;
                  hist_in = 16'h0000;
                  col_in  = 12'd0;
                  row_in  = 24'd0;
                  stat_in = nfci_pkg::STATUS_RESET;
               end
               nfci_pkg::CMD_PROG2, nfci_pkg::CMD_READ1, nfci_pkg::CMD_STATUS,
               nfci_pkg::CMD_ERASE2, nfci_pkg::CMD_RNDOUT2: ;
               default: job.fault = nfci_pkg::FAULT_UNKNOWN;
            endcase
            unique case (hist_in)
               nfci_pkg::HIST_READ: begin
                  col_in  = col_new;
                  row_in  = row_hi;
                  job.op  = nfci_pkg::OP_LOAD;
                  job.row = row_hi;
               end
               nfci_pkg::HIST_RNDOUT: col_in = col_new;
               nfci_pkg::HIST_PROG: begin
                  col_in  = col_new;
                  row_in  = row_hi;
                  job.op  = nfci_pkg::OP_PROGRAM;
                  job.row = row_hi;
               end
               nfci_pkg::HIST_ERASE: begin
                  row_in  = row_lo;
                  job.op  = nfci_pkg::OP_ERASE;
                  job.row = row_lo;
               end
               default: ;
            endcase
         end
         default: begin
            if (acnt_ff < 4'd8) begin
               ab_in[acnt_ff[2:0]] = v;
               acnt_in = acnt_ff + 4'd1;
            end
            if (hist_ff[7:0] == nfci_pkg::CMD_ID) col_in = {4'h0, ab_in[0]};
         end
      endcase
   end

   // Command registers advance on each accepted transfer; the ID register takes csr writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff   <= nfci_pkg::ID_RESET;
         hist_ff <= 16'h0000;
         for (int k = 0; k < 8; k++) ab_ff[k] <= 8'h00;
         acnt_ff <= 4'd0;
         col_ff  <= 12'd0;
         row_ff  <= 24'd0;
         stat_ff <= 8'h00;
      end else begin
         id_ff <= id_in;
         if (fire) begin
            hist_ff <= hist_in;
            ab_ff   <= ab_in;
            acnt_ff <= acnt_in;
            col_ff  <= col_in;
            row_ff  <= row_in;
            stat_ff <= stat_in;
         end
      end
   end

endmodule

### src/nfci_queue.sv
// Short job queue between the front and back parts.
module nfci_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  nfci_pkg::job_type in_job,
   output logic              out_valid,
   input  logic              out_ready,
   output nfci_pkg::job_type out_job
);

   nfci_pkg::job_type mem_ff [nfci_pkg::QUEUE_DEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'(nfci_pkg::QUEUE_DEPTH);
   assign out_valid = cnt_ff != 2'd0;
   assign out_job   = mem_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update.
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_job;
   end

endmodule

### src/nfci_back.sv
// Back part: page register, page store and the copy and erase sequencer.
module nfci_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  nfci_pkg::job_type job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nfci_pkg::rsp_type rsp_data
);

   localparam int AW = nfci_pkg::PREG_AW;
   localparam int SW = nfci_pkg::STORE_AW;
   localparam int PW = nfci_pkg::PIDX_W;

   nfci_pkg::back_state_type state_ff, state_in;
   logic [7:0]  preg [nfci_pkg::PAGE_BYTES];
   logic [7:0]  store [nfci_pkg::PAGE_COUNT * nfci_pkg::PAGE_BYTES];
   logic        written [nfci_pkg::PAGE_COUNT];
   logic [7:0]  preg_q, store_q;
   logic        written_q;
   logic [AW:0] cnt_ff, cnt_in;
   logic [AW-1:0] wa_ff;
   logic        wv_ff;
   logic        row_ok_ff;
   nfci_pkg::op_type op_ff;
   logic [PW-1:0] pidx_ff;
   nfci_pkg::rsp_type rsp_ff;
   logic [23:0] blk_full;
   logic        row_ok;
   logic [PW-1:0] pidx_new;
   logic        take, done_cnt, done_erase, done_clear;
   logic        src_erased;
   logic [AW-1:0] ra;
   logic        preg_we, store_we;
   logic [AW-1:0] preg_wa;
   logic [7:0]  preg_wd;
   logic [SW-1:0] page_base, store_ra, store_wa;
   logic        wr_we, wr_wd;
   logic [PW-1:0] wr_wa;

   assign blk_full   = job.row >> nfci_pkg::PPB_W;
   assign row_ok     = blk_full < 24'(nfci_pkg::BLOCK_COUNT);
   assign pidx_new   = PW'(job.row);
   assign take       = job_valid && job_ready;
   assign done_cnt   = cnt_ff == (AW+1)'(nfci_pkg::PAGE_BYTES);
   assign done_erase = cnt_ff == (AW+1)'(nfci_pkg::PAGES_PER_BLOCK - 1);
   assign done_clear = cnt_ff == (AW+1)'(nfci_pkg::PAGE_COUNT - 1);
   assign ra         = cnt_ff[AW-1:0];
   assign src_erased = !row_ok_ff || !written_q;

   // Page store addresses: page index times page size plus the byte offset.
   assign page_base = SW'(pidx_ff) * SW'(nfci_pkg::PAGE_BYTES);
   assign store_ra  = page_base + SW'(ra);
   assign store_wa  = page_base + SW'(wa_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nfci_pkg::BS_IDLE: begin
            if (job_valid) begin
               unique case (job.op)
                  nfci_pkg::OP_PREG_READ: state_in = nfci_pkg::BS_RD_WAIT;
                  nfci_pkg::OP_LOAD, nfci_pkg::OP_PROGRAM:
                     state_in = row_ok ? nfci_pkg::BS_COPY : nfci_pkg::BS_RESP;
                  nfci_pkg::OP_ERASE:
                     state_in = row_ok ? nfci_pkg::BS_ERASE : nfci_pkg::BS_RESP;
                  default: state_in = nfci_pkg::BS_RESP;
               endcase
               if (job.op == nfci_pkg::OP_LOAD) state_in = nfci_pkg::BS_COPY;
            end
         end
         nfci_pkg::BS_RD_WAIT: state_in = nfci_pkg::BS_RESP;
         nfci_pkg::BS_COPY:    if (done_cnt) state_in = nfci_pkg::BS_RESP;
         nfci_pkg::BS_ERASE:   if (done_erase) state_in = nfci_pkg::BS_RESP;
         nfci_pkg::BS_RESP:    if (rsp_ready) state_in = nfci_pkg::BS_IDLE;
         nfci_pkg::BS_CLEAR:   if (done_clear) state_in = nfci_pkg::BS_IDLE;
         default:              state_in = nfci_pkg::BS_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      job_ready = state_ff == nfci_pkg::BS_IDLE;
      rsp_valid = state_ff == nfci_pkg::BS_RESP;
      rsp_data  = rsp_ff;
      cnt_in    = (state_ff == nfci_pkg::BS_COPY || state_ff == nfci_pkg::BS_ERASE ||
                   state_ff == nfci_pkg::BS_CLEAR) ? cnt_ff + (AW+1)'(1) : '0;
      preg_we   = 1'b0;
      preg_wa   = job.addr;
      preg_wd   = job.data;
      store_we  = 1'b0;
      wr_we     = 1'b0;
      wr_wa     = pidx_ff;
      wr_wd     = 1'b0;
      if (take && job.op == nfci_pkg::OP_PREG_WRITE) preg_we = 1'b1;
      if (state_ff == nfci_pkg::BS_COPY && op_ff == nfci_pkg::OP_LOAD && wv_ff) begin
         preg_we = 1'b1;
         preg_wa = wa_ff;
         preg_wd = src_erased ? nfci_pkg::erased_byte(wa_ff) : store_q;
      end
      if (state_ff == nfci_pkg::BS_COPY && op_ff == nfci_pkg::OP_PROGRAM && wv_ff)
         store_we = 1'b1;
      // Written flags: set at the end of a program, cleared one page a cycle.
      if (state_ff == nfci_pkg::BS_COPY && done_cnt && op_ff == nfci_pkg::OP_PROGRAM) begin
         wr_we = 1'b1;
         wr_wd = 1'b1;
      end
      if (state_ff == nfci_pkg::BS_ERASE) begin
         wr_we = 1'b1;
         wr_wa = {pidx_ff[PW-1:nfci_pkg::PPB_W], cnt_ff[nfci_pkg::PPB_W-1:0]};
      end
      if (state_ff == nfci_pkg::BS_CLEAR) begin
         wr_we = 1'b1;
         wr_wa = cnt_ff[PW-1:0];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nfci_pkg::BS_CLEAR;
         cnt_ff   <= '0;
         wv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         wv_ff    <= state_ff == nfci_pkg::BS_COPY && !done_cnt;
      end
   end

   // Job capture and the response register.
   always_ff @(posedge clock) begin
      wa_ff <= ra;
      if (take) begin
         op_ff     <= job.op;
         pidx_ff   <= pidx_new;
         row_ok_ff <= row_ok;
         rsp_ff.read_byte <= (job.op == nfci_pkg::OP_PREG_WRITE) ? 8'h00 : job.data;
         rsp_ff.fault     <= job.fault;
      end
      if (state_ff == nfci_pkg::BS_RD_WAIT) rsp_ff.read_byte <= preg_q;
      if (state_ff == nfci_pkg::BS_COPY) rsp_ff.read_byte <= 8'h00;
   end

   // Page written flags.
   always_ff @(posedge clock) begin
      if (wr_we) written[wr_wa] <= wr_wd;
      if (take) written_q <= written[pidx_new];
   end

   // Page register memory.
   always_ff @(posedge clock) begin
      if (preg_we) preg[preg_wa] <= preg_wd;
      preg_q <= preg[(state_ff == nfci_pkg::BS_COPY) ? ra : job.addr];
   end

   // Page store memory.
   always_ff @(posedge clock) begin
      if (store_we) store[store_wa] <= preg_q;
      store_q <= store[store_ra];
   end

endmodule

### src/nand_flash_command_interface.sv
// Top level of the NAND flash command interface.
// Requests carry a function code and a bus byte over req_valid/req_ready;
// every transfer gives exactly one response on rsp_valid/rsp_ready holding
// the read byte (zero on writes) and a fault code. csr_we writes the 40-bit
// ID code at once, lowest byte returned first.
// A front part decodes commands and addresses and hands jobs to a two-entry
// queue; a back part owns the page register and page store and answers.
// A byte transfer passes through the queue to the back part, which answers
// from its response register; a page register read first waits for its
// registered memory read. The back part takes no new job until the last
// response is taken. Page read and program copy the page register one byte
// a cycle, then answer; a program to a row beyond the store copies nothing.
// Erase clears the written flags of one block one page a cycle, then answers.
// Reset is synchronous: command state and the queue clear, then the back
// part clears the written flag of every page, so every page reads as erased;
// up to two requests queue meanwhile. The page register and store contents
// are undefined until written. When the receiver stalls the response holds
// and the back part waits; the queue then fills and the request side stalls.
module nand_flash_command_interface (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nfci_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nfci_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [39:0]       csr_wdata
);

   logic              fq_valid, fq_ready, qb_valid, qb_ready;
   nfci_pkg::job_type fq_job, qb_job;

   nfci_front u_front (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
   );

   nfci_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_job(qb_job)
   );

   nfci_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

endmodule

### test/tb_nand_flash_command_interface.sv
// Self-checking testbench for the NAND flash command interface.
module tb_nand_flash_command_interface;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          WATCHDOG_LIMIT = 40000;
   localparam int          ITEM_TARGET    = 650;
   localparam logic [7:0]  CMD_UNKNOWN    = 8'h42;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   nfci_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   nfci_pkg::rsp_type rsp_data;
   logic              csr_we;
   logic [39:0]       csr_wdata;

   // Shadow state of the flash chip.
   logic [39:0] id_code;
   logic [15:0] cmd_hist;
   logic [7:0]  addr_bytes [8];
   int          addr_count;
   logic [11:0] column;
   logic [23:0] row;
   logic [7:0]  status_reg;
   logic [7:0]  page_reg [nfci_pkg::PAGE_BYTES];
   logic [7:0]  page_mem [nfci_pkg::PAGE_COUNT * nfci_pkg::PAGE_BYTES];
   logic        page_written [nfci_pkg::PAGE_COUNT];

   nfci_pkg::rsp_type expected_rsp [$];
   int          mismatches;
   int          items_sent;
   int          hold_cycles;
   bit          sender_idle_on;
   bit          receiver_idle_on;
   bit          timed_out;

   nand_flash_command_interface dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Copy the addressed page into the page register, or the erased pattern.
   task automatic load_page();
      int blk;
      int idx;
      int s;
      blk = row / nfci_pkg::PAGES_PER_BLOCK;
      idx = row % nfci_pkg::PAGES_PER_BLOCK + blk * nfci_pkg::PAGES_PER_BLOCK;
      if (blk < nfci_pkg::BLOCK_COUNT && page_written[idx]) begin
         for (int i = 0; i < nfci_pkg::PAGE_BYTES; i++)
            page_reg[i] = page_mem[idx * nfci_pkg::PAGE_BYTES + i];
      end else begin
         for (int i = 0; i < nfci_pkg::PAGE_BYTES; i++) begin
            s = i - nfci_pkg::PAGE_DATA_BYTES;
            if (i < nfci_pkg::PAGE_DATA_BYTES) page_reg[i] = 8'hFF;
            else page_reg[i] = (s < 64 && s % 16 < 2) ? 8'hFF : 8'h00;
         end
      end
   endtask

   // Handle a command byte, including the two-byte sequences it completes.
   task automatic flash_command(input logic [7:0] v, output logic [1:0] fault);
      logic [11:0] col_addr;
      logic [23:0] row_hi;
      logic [23:0] row_lo;
      int blk;
      int idx;
      fault = nfci_pkg::FAULT_OK;
      cmd_hist = {cmd_hist[7:0], v};
      case (v)
         nfci_pkg::CMD_READ0, nfci_pkg::CMD_RNDOUT, nfci_pkg::CMD_ERASE1, nfci_pkg::CMD_ID,
         nfci_pkg::CMD_PROG1, nfci_pkg::CMD_RESET: begin
            foreach (addr_bytes[i]) addr_bytes[i] = 8'h00;
            addr_count = 0;
            if (v == nfci_pkg::CMD_PROG1) column = '0;
            if (v == nfci_pkg::CMD_RESET) begin
               cmd_hist = '0;
               column = '0;
               row = '0;
               status_reg = nfci_pkg::STATUS_RESET;
            end
         end
         nfci_pkg::CMD_PROG2, nfci_pkg::CMD_READ1, nfci_pkg::CMD_STATUS, nfci_pkg::CMD_ERASE2,
         nfci_pkg::CMD_RNDOUT2: ;
         default: fault = nfci_pkg::FAULT_UNKNOWN;
      endcase
      col_addr = {addr_bytes[1][3:0], addr_bytes[0]};
      row_hi = {addr_bytes[4], addr_bytes[3], addr_bytes[2]};
      row_lo = {addr_bytes[2], addr_bytes[1], addr_bytes[0]};
      case (cmd_hist)
         nfci_pkg::HIST_READ: begin
            column = col_addr;
            row = row_hi;
            load_page();
         end
         nfci_pkg::HIST_RNDOUT: column = col_addr;
         nfci_pkg::HIST_PROG: begin
            column = col_addr;
            row = row_hi;
            blk = row / nfci_pkg::PAGES_PER_BLOCK;
            idx = row % nfci_pkg::PAGES_PER_BLOCK + blk * nfci_pkg::PAGES_PER_BLOCK;
            if (blk < nfci_pkg::BLOCK_COUNT) begin
               for (int i = 0; i < nfci_pkg::PAGE_BYTES; i++)
                  page_mem[idx * nfci_pkg::PAGE_BYTES + i] = page_reg[i];
               page_written[idx] = 1'b1;
            end
         end
         nfci_pkg::HIST_ERASE: begin
            row = row_lo;
            blk = row / nfci_pkg::PAGES_PER_BLOCK;
            if (blk < nfci_pkg::BLOCK_COUNT)
               for (int p = 0; p < nfci_pkg::PAGES_PER_BLOCK; p++)
                  page_written[blk * nfci_pkg::PAGES_PER_BLOCK + p] = 1'b0;
         end
         default: ;
      endcase
   endtask

   // Work out the response to one transfer and advance the shadow state.
   task automatic flash_step(input nfci_pkg::req_type r, output nfci_pkg::rsp_type e);
      logic [7:0] d;
      logic [1:0] f;
      d = 8'h00;
      f = nfci_pkg::FAULT_OK;
      case (r.func)
         nfci_pkg::FUNC_READ: begin
            case (cmd_hist[7:0])
               nfci_pkg::CMD_STATUS: d = status_reg;
               nfci_pkg::CMD_ID: begin
                  if (column < 5) begin
                     d = 8'(id_code >> (8 * column));
                     column = column + 1'b1;
                  end
               end
               nfci_pkg::CMD_READ0, nfci_pkg::CMD_READ1, nfci_pkg::CMD_RNDOUT2: begin
                  if (column < nfci_pkg::PAGE_BYTES) begin
                     d = page_reg[column];
                     column = column + 1'b1;
                  end
               end
               default: f = nfci_pkg::FAULT_READ;
            endcase
         end
         nfci_pkg::FUNC_WRITE: begin
            if (column < nfci_pkg::PAGE_BYTES) begin
               page_reg[column] = r.bus_byte;
               column = column + 1'b1;
            end
         end
         nfci_pkg::FUNC_CMD: flash_command(r.bus_byte, f);
         default: begin
            if (addr_count < 8) begin
               addr_bytes[addr_count] = r.bus_byte;
               addr_count++;
            end
            if (cmd_hist[7:0] == nfci_pkg::CMD_ID) column = {4'h0, addr_bytes[0]};
         end
      endcase
      e.read_byte = d;
      e.fault = f;
   endtask

   // Offer one item, optionally after an idle burst, and predict it on transfer.
   task automatic send_transfer(input logic [1:0] func, input logic [7:0] value);
      nfci_pkg::rsp_type e;
      nfci_pkg::req_type r;
      int gap;
      if (sender_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 9);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      r.func = func;
      r.bus_byte = value;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      flash_step(r, e);
      expected_rsp.push_back(e);
      items_sent++;
   endtask

   // Drop valid and wait until every response is back and the block is quiet.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_rsp.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_id(input logic [39:0] v);
      drain();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      id_code = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_addr5(input logic [11:0] col, input logic [23:0] r);
      send_transfer(nfci_pkg::FUNC_ADDR, col[7:0]);
      send_transfer(nfci_pkg::FUNC_ADDR, {4'h0, col[11:8]});
      send_transfer(nfci_pkg::FUNC_ADDR, r[7:0]);
      send_transfer(nfci_pkg::FUNC_ADDR, r[15:8]);
      send_transfer(nfci_pkg::FUNC_ADDR, r[23:16]);
   endtask

   function automatic logic [23:0] pick_row();
      if ($urandom_range(0, 9) == 0) return 24'($urandom());
      return 24'($urandom_range(0, nfci_pkg::PAGE_COUNT - 1));
   endfunction

   function automatic logic [11:0] pick_column();
      case ($urandom_range(0, 3))
         0: return 12'($urandom_range(0, 15));
         1: return 12'($urandom_range(nfci_pkg::PAGE_BYTES - 12, nfci_pkg::PAGE_BYTES + 4));
         2: return 12'($urandom());
         default: return 12'($urandom_range(0, nfci_pkg::PAGE_BYTES - 1));
      endcase
   endfunction

   // Page read from the start of page zero, which also defines the page register.
   task automatic test_page_read();
      send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_READ0);
      send_addr5(12'h000, 24'h000000);
      send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_READ1);
      repeat (3) send_transfer(nfci_pkg::FUNC_READ, 8'h00);
   endtask

   // Reset, status, ID with reading past the fifth byte, unknown command.
   task automatic test_status_and_id();
      send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_RESET);
      send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_STATUS);
      send_transfer(nfci_pkg::FUNC_READ, 8'hFF);
      send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_ID);
      send_transfer(nfci_pkg::FUNC_ADDR, 8'h00);
      repeat (6) send_transfer(nfci_pkg::FUNC_READ, 8'h00);
      send_transfer(nfci_pkg::FUNC_CMD, CMD_UNKNOWN);
      send_transfer(nfci_pkg::FUNC_READ, 8'h00);
   endtask

   // Program the last page, read back with random output, erase and reread.
   task automatic test_program_and_erase();
      send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_PROG1);
      send_transfer(nfci_pkg::FUNC_WRITE, 8'hA5);
      send_transfer(nfci_pkg::FUNC_WRITE, 8'hFF);
      send_addr5(12'hFFF, 24'(nfci_pkg::PAGE_COUNT - 1));
      send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_PROG2);
      send_transfer(nfci_pkg::FUNC_READ, 8'h00);
      send_transfer(nfci_pkg::FUNC_WRITE, 8'h5A);
      send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_RNDOUT);
      send_transfer(nfci_pkg::FUNC_ADDR, 8'h00);
      send_transfer(nfci_pkg::FUNC_ADDR, 8'h00);
      send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_RNDOUT2);
      send_transfer(nfci_pkg::FUNC_READ, 8'h00);
      send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_ERASE1);
      send_transfer(nfci_pkg::FUNC_ADDR, 8'hFF);
      send_transfer(nfci_pkg::FUNC_ADDR, 8'h01);
      send_transfer(nfci_pkg::FUNC_ADDR, 8'h00);
      send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_ERASE2);
      send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_READ0);
      send_addr5(12'h000, 24'(nfci_pkg::PAGE_COUNT - 1));
      send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_READ1);
      send_transfer(nfci_pkg::FUNC_READ, 8'h00);
   endtask

   // The receiver holds off while status reads pile up behind it.
   task automatic test_receiver_hold();
      send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_STATUS);
      hold_cycles = 300;
      repeat (20) send_transfer(nfci_pkg::FUNC_READ, 8'h00);
   endtask

   // Random well-formed command sequences mixed with noise.
   task automatic test_random_traffic(input int count);
      int stop_at;
      int n;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         n = $urandom_range(1, 8);
         case ($urandom_range(0, 19))
            0: begin
               send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_READ0);
               send_addr5(pick_column(), pick_row());
               send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_READ1);
               repeat (n) send_transfer(nfci_pkg::FUNC_READ, 8'($urandom()));
            end
            1: begin
               send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_PROG1);
               repeat (n) send_transfer(nfci_pkg::FUNC_WRITE, 8'($urandom()));
               send_addr5(pick_column(), pick_row());
               send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_PROG2);
            end
            2, 3: begin
               send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_ERASE1);
               if ($urandom_range(0, 1)) begin
                  for (int i = 0; i < 3; i++)
                     send_transfer(nfci_pkg::FUNC_ADDR, 8'($urandom()));
               end else begin
                  n = $urandom_range(0, nfci_pkg::PAGE_COUNT - 1);
                  send_transfer(nfci_pkg::FUNC_ADDR, 8'(n));
                  send_transfer(nfci_pkg::FUNC_ADDR, 8'(n >> 8));
                  send_transfer(nfci_pkg::FUNC_ADDR, 8'h00);
               end
               send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_ERASE2);
            end
            4, 5, 6: begin
               n = pick_column();
               send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_RNDOUT);
               send_transfer(nfci_pkg::FUNC_ADDR, 8'(n));
               send_transfer(nfci_pkg::FUNC_ADDR, 8'(n >> 8));
               send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_RNDOUT2);
               repeat ($urandom_range(1, 8)) begin
                  if ($urandom_range(0, 4) == 0)
                     send_transfer(nfci_pkg::FUNC_WRITE, 8'($urandom()));
                  else send_transfer(nfci_pkg::FUNC_READ, 8'($urandom()));
               end
            end
            7, 8: begin
               send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_ID);
               send_transfer(nfci_pkg::FUNC_ADDR, 8'($urandom_range(0, 6)));
               repeat (n) send_transfer(nfci_pkg::FUNC_READ, 8'h00);
            end
            9: begin
               send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_STATUS);
               repeat (n) send_transfer(nfci_pkg::FUNC_READ, 8'h00);
            end
            10: send_transfer(nfci_pkg::FUNC_CMD, nfci_pkg::CMD_RESET);
            11, 12: begin
               // Random command bytes and address floods, including past eight bytes.
               repeat (n) begin
                  if ($urandom_range(0, 1))
                     send_transfer(nfci_pkg::FUNC_ADDR, 8'($urandom()));
                  else send_transfer(nfci_pkg::FUNC_CMD, 8'($urandom()) | 8'h01);
               end
            end
            default: begin
               repeat (n)
                  send_transfer(nfci_pkg::FUNC_READ + 2'($urandom_range(0, 1)),
                                8'($urandom()));
            end
         endcase
      end
   endtask

   // Receiver: ready with random stall bursts, and long hold-offs on request.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      stall = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (receiver_idle_on && $urandom_range(0, 6) == 0) begin
            stall = $urandom_range(0, 8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare every response transfer with the oldest prediction.
   initial begin
      nfci_pkg::rsp_type e;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: read_byte %h fault %0d",
                           rsp_data.read_byte, rsp_data.fault);
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_data.read_byte !== e.read_byte || rsp_data.fault !== e.fault) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected read_byte %h fault %0d, got %h fault %0d",
                              e.read_byte, e.fault, rsp_data.read_byte, rsp_data.fault);
               end
            end
         end
      end
   end

   // Watchdog on cycles without any transfer on either channel.
   initial begin
      int quiet;
      quiet = 0;
      timed_out = 1'b0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet = 0;
         else quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      mismatches = 0;
      items_sent = 0;
      hold_cycles = 0;
      sender_idle_on = 1'b1;
      receiver_idle_on = 1'b1;
      id_code = nfci_pkg::ID_RESET;
      cmd_hist = '0;
      foreach (addr_bytes[i]) addr_bytes[i] = 8'h00;
      addr_count = 0;
      column = '0;
      row = '0;
      status_reg = 8'h00;
      foreach (page_written[i]) page_written[i] = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_page_read();
      test_status_and_id();
      write_id(40'h0);
      test_status_and_id();
      write_id(40'hFF_FFFF_FFFF);
      test_program_and_erase();
      test_status_and_id();
      test_receiver_hold();
      write_id(40'($urandom()) << 8 | 40'($urandom_range(0, 255)));
      test_random_traffic(250);
      // Sender waits for every response before carrying on.
      drain();
      write_id(nfci_pkg::ID_RESET);
      test_random_traffic(ITEM_TARGET - items_sent - 100);
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      test_random_traffic(100);
      drain();
      repeat (30) @(posedge clock);

      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
